// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/pgs3d_pkg.sv =====
`timescale 1ns / 1ps

package pgs3d_pkg;

  // default grid extent along each axis
  localparam int GridXDefault = 32;
  localparam int GridYDefault = 32;
  localparam int GridZDefault = 32;

  localparam int DataW    = 32;  // Q16.16 sample / force
  localparam int IndexW   = 5;   // input coordinate width
  localparam int CoordW   = 9;   // working width for coordinate arithmetic
  localparam int GridW    = 10;  // holds a grid extent up to 256 and twice that
  localparam int WeightW  = 7;   // stencil weights up to +-45
  localparam int AccW     = 39;  // |S| <= 55 * 2^32
  localparam int MagW     = 38;
  localparam int HalfW    = 16;  // inverse spacing processed in 16-bit halves
  localparam int MulAW    = 40;
  localparam int MulBW    = 18;
  localparam int MulW     = MulAW + MulBW;
  localparam int PartW    = MagW + HalfW;
  localparam int ProdW    = 71;  // |S| * inv plus rounding bias
  localparam int DigitW   = 8;   // divider takes one byte per cycle
  localparam int DivW     = 56;
  localparam int DivSteps = DivW / DigitW;
  localparam int RemW     = 4;
  localparam int ShiftOrd2 = 17; // 2 * 65536
  localparam int ShiftOrdN = 18; // 4 * 65536, leaving /3 or /15
  localparam int RegAddrW  = 4;

  // register map (word index)
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_INV_X = 2'd1;
  localparam logic [1:0] REG_INV_Y = 2'd2;
  localparam logic [1:0] REG_INV_Z = 2'd3;

  localparam logic [1:0] ORDER_2ND = 2'd0;
  localparam logic [1:0] ORDER_4TH = 2'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [DataW-1:0] InvReset = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_MAC = 2'd0,
    MODE_LO  = 2'd1,
    MODE_HI  = 2'd2
  } mul_mode_e;

  typedef struct packed {
    logic                       valid;
    mul_mode_e                  mode;
    logic signed [WeightW-1:0]  weight;
  } mul_tag_t;

  // reads per axis: p1, m1, p2, m2, p3, m3 in that order
  function automatic logic [2:0] read_count(input logic [1:0] order);
    case (order)
      ORDER_2ND: return 3'd2;
      ORDER_4TH: return 3'd4;
      default:   return 3'd6;
    endcase
  endfunction

  function automatic logic signed [WeightW-1:0] stencil_weight(input logic [1:0] order,
                                                               input logic [2:0] k);
    case (order)
      ORDER_2ND: begin
        case (k)
          3'd0:    return 7'sd1;
          3'd1:    return -7'sd1;
          default: return 7'sd0;
        endcase
      end
      ORDER_4TH: begin
        case (k)
          3'd0:    return 7'sd8;
          3'd1:    return -7'sd8;
          3'd2:    return -7'sd1;
          3'd3:    return 7'sd1;
          default: return 7'sd0;
        endcase
      end
      default: begin
        case (k)
          3'd0:    return 7'sd45;
          3'd1:    return -7'sd45;
          3'd2:    return -7'sd9;
          3'd3:    return 7'sd9;
          3'd4:    return 7'sd1;
          3'd5:    return -7'sd1;
          default: return 7'sd0;
        endcase
      end
    endcase
  endfunction

  // half the denominator, D * 32768, added before the truncating divide
  function automatic logic [ProdW-1:0] round_bias(input logic [1:0] order);
    case (order)
      ORDER_2ND: return ProdW'(65536);
      ORDER_4TH: return ProdW'(393216);
      default:   return ProdW'(1966080);
    endcase
  endfunction

  // odd part of the denominator left after the shift
  function automatic logic [RemW-1:0] odd_divisor(input logic [1:0] order);
    case (order)
      ORDER_2ND: return 4'd1;
      ORDER_4TH: return 4'd3;
      default:   return 4'd15;
    endcase
  endfunction

  // one byte of restoring division by a small odd constant; returns {q, r}
  function automatic logic [DigitW+RemW-1:0] div_digit(input logic [RemW-1:0]   rem,
                                                       input logic [DigitW-1:0] digit,
                                                       input logic [RemW-1:0]   k);
    logic [RemW:0]     r;
    logic [DigitW-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = DigitW - 1; i >= 0; i--) begin
      r = {r[RemW-1:0], digit[i]};
      if (r >= {1'b0, k}) begin
        r    = r - {1'b0, k};
        q[i] = 1'b1;
      end
    end
    return {q, r[RemW-1:0]};
  endfunction

  // input coordinate modulo grid extent (at most three subtractions for g >= 8)
  function automatic logic [CoordW-1:0] reduce_coord(input logic [IndexW-1:0] idx,
                                                     input logic [GridW-1:0]  g);
    logic [GridW-1:0] v;
    v = GridW'(idx);
    for (int i = 0; i < 4; i++) begin
      if (v >= g) v = v - g;
    end
    return v[CoordW-1:0];
  endfunction

  // periodic neighbour coordinate, distance 1..3 up or down
  function automatic logic [CoordW-1:0] wrap_coord(input logic [CoordW-1:0] c,
                                                   input logic [1:0]        span,
                                                   input logic              down,
                                                   input logic [GridW-1:0]  g);
    logic [GridW:0] t;
    logic [GridW:0] g2;
    g2 = {g, 1'b0};
    t  = (GridW+1)'(c) + (GridW+1)'(g);
    if (down) t = t - (GridW+1)'(span);
    else      t = t + (GridW+1)'(span);
    if (t >= g2)                     t = t - g2;
    else if (t >= (GridW+1)'(g))     t = t - (GridW+1)'(g);
    return t[CoordW-1:0];
  endfunction

endpackage

// ===== src/periodic_gradient_stencil_3d_unit.sv =====
`timescale 1ns / 1ps
// Periodic 3D central-difference force unit. A word with action 0 stores one Q16.16
// potential sample in the grid memory in the cycle it is taken; busy stays low. A word
// with action 1 returns the force (negative gradient, wrap-around neighbours) at that
// point while busy stays high; each axis takes 2, 4 or 6 neighbour reads for second,
// fourth or sixth order. Per axis the time is set by one neighbour read per cycle from
// the single-port grid memory, a shared 40x18 multiplier used for the weighted sum and
// then for the two halves of the spacing product, and a one-byte-per-cycle divider for
// the /12 and /60 scaling. The result word is shown for exactly one cycle, marked by
// valid_o, in the cycle busy falls, and must be taken then. The grid memory is not
// cleared: every neighbour a query touches must have been written first. Registers may
// only be written while busy is low.
module periodic_gradient_stencil_3d_unit import pgs3d_pkg::*; #(
  parameter int GRID_X = GridXDefault,
  parameter int GRID_Y = GridYDefault,
  parameter int GRID_Z = GridZDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action_i,
  input  logic [IndexW-1:0]         index_x_i,
  input  logic [IndexW-1:0]         index_y_i,
  input  logic [IndexW-1:0]         index_z_i,
  input  logic signed [DataW-1:0]   potential_i,
  output logic                      valid_o,
  output logic signed [DataW-1:0]   force_x_o,
  output logic signed [DataW-1:0]   force_y_o,
  output logic signed [DataW-1:0]   force_z_o,
  output logic                      saturated_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [RegAddrW-1:0]       paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

`include "assert_macros.svh"

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int Depth = 2 ** AW;
  localparam logic [GridW-1:0] GX = GridW'(GRID_X);
  localparam logic [GridW-1:0] GY = GridW'(GRID_Y);
  localparam logic [GridW-1:0] GZ = GridW'(GRID_Z);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_READ   = 7'b000_0010,
    ST_MDRAIN = 7'b000_0100,
    ST_PMUL   = 7'b000_1000,
    ST_PDRAIN = 7'b001_0000,
    ST_DIV    = 7'b010_0000,
    ST_FIN    = 7'b100_0000
  } state_e;

  // control
  state_e           state_q, state_d;
  logic [2:0]       k_q, k_d;
  logic             p_q, p_d;
  logic [2:0]       step_q, step_d;
  logic [1:0]       axis_q, axis_d;
  mul_tag_t         t1_q, t1_d, t2_q, t2_d;
  logic             valid_q, valid_d;
  logic             sat_q, sat_d;
  logic [1:0]       order_q;
  logic [DataW-1:0] inv_x_q, inv_y_q, inv_z_q;

  // datapath
  logic [XW-1:0]            x_q, x_d;
  logic [YW-1:0]            y_q, y_d;
  logic [ZW-1:0]            z_q, z_d;
  logic signed [DataW-1:0]  rdata_q;
  logic signed [MulW-1:0]   mul_q, mul_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [MagW-1:0]          mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [ProdW-1:0]         prod_q, prod_d;
  logic [DivW-1:0]          div_q, div_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [DivW-1:0]          quot_q, quot_d;
  logic [DataW-1:0]         force_x_q, force_x_d;
  logic [DataW-1:0]         force_y_q, force_y_d;
  logic [DataW-1:0]         force_z_q, force_z_d;
  logic                     saturated_q, saturated_d;

  logic signed [DataW-1:0]  potential_mem [Depth];

  logic [CoordW-1:0] in_x, in_y, in_z;
  logic [CoordW-1:0] wx, wy, wz;
  logic [1:0]        nb_dist;
  logic [AW-1:0]     wr_addr, rd_addr, mem_addr;
  logic              mem_we, mem_re;
  logic [2:0]        last_k;
  logic              pipe_empty;
  logic [DataW-1:0]  inv_sel;
  logic [HalfW-1:0]  inv_half;
  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic [AccW-1:0]   acc_neg;
  logic [DigitW+RemW-1:0] digit_res;
  logic [DivW-1:0]   lim;
  logic              over;
  logic [DataW-1:0]  mag_clip, force_val;

  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;

  // ---- configuration port ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_2ND;
      inv_x_q <= InvReset;
      inv_y_q <= InvReset;
      inv_z_q <= InvReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ORDER: order_q <= pwdata[1:0];
        REG_INV_X: inv_x_q <= pwdata;
        REG_INV_Y: inv_y_q <= pwdata;
        REG_INV_Z: inv_z_q <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORDER: prdata = {{(DataW-2){1'b0}}, order_q};
      REG_INV_X: prdata = inv_x_q;
      REG_INV_Y: prdata = inv_y_q;
      REG_INV_Z: prdata = inv_z_q;
      default:   prdata = '0;
    endcase
  end

  // ---- addressing ----
  assign in_x = reduce_coord(index_x_i, GX);
  assign in_y = reduce_coord(index_y_i, GY);
  assign in_z = reduce_coord(index_z_i, GZ);
  assign wr_addr = {in_x[XW-1:0], in_y[YW-1:0], in_z[ZW-1:0]};

  // read k: even k goes up, odd k goes down, distance k/2 + 1
  assign nb_dist = k_q[2:1] + 2'd1;
  assign wx = (axis_q == AXIS_X) ? wrap_coord(CoordW'(x_q), nb_dist, k_q[0], GX)
                                 : CoordW'(x_q);
  assign wy = (axis_q == AXIS_Y) ? wrap_coord(CoordW'(y_q), nb_dist, k_q[0], GY)
                                 : CoordW'(y_q);
  assign wz = (axis_q == AXIS_Z) ? wrap_coord(CoordW'(z_q), nb_dist, k_q[0], GZ)
                                 : CoordW'(z_q);
  assign rd_addr = {wx[XW-1:0], wy[YW-1:0], wz[ZW-1:0]};

  assign mem_we   = (state_q == ST_IDLE) && start && (action_i == ACT_WRITE);
  assign mem_re   = (state_q == ST_READ);
  assign mem_addr = mem_re ? rd_addr : wr_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) potential_mem[mem_addr] <= potential_i;
    if (mem_re) rdata_q <= potential_mem[mem_addr];
  end

  // ---- shared multiplier ----
  always_comb begin
    unique case (axis_q)
      AXIS_X:  inv_sel = inv_x_q;
      AXIS_Y:  inv_sel = inv_y_q;
      default: inv_sel = inv_z_q;
    endcase
  end

  assign inv_half = (t1_q.mode == MODE_HI) ? inv_sel[DataW-1:HalfW] : inv_sel[HalfW-1:0];

  always_comb begin
    if (t1_q.mode == MODE_MAC) begin
      op_a = {{(MulAW-DataW){rdata_q[DataW-1]}}, rdata_q};
      op_b = {{(MulBW-WeightW){t1_q.weight[WeightW-1]}}, t1_q.weight};
    end else begin
      op_a = {{(MulAW-MagW){1'b0}}, mag_q};
      op_b = {{(MulBW-HalfW){1'b0}}, inv_half};
    end
  end

  assign mul_d = op_a * op_b;

  // ---- helpers for the sequencer ----
  assign last_k     = read_count(order_q) - 3'd1;
  assign pipe_empty = !t1_q.valid && !t2_q.valid;
  assign acc_neg    = '0 - acc_q;
  assign digit_res  = div_digit(rem_q, div_q[DivW-1 -: DigitW], odd_divisor(order_q));

  // a positive force (negative sum) may reach 2^31 - 1, a negative one 2^31
  assign lim       = neg_q ? DivW'(32'h7FFF_FFFF) : DivW'(32'h8000_0000);
  assign over      = (quot_q > lim);
  assign mag_clip  = over ? lim[DataW-1:0] : quot_q[DataW-1:0];
  assign force_val = neg_q ? mag_clip : ('0 - mag_clip);

  // ---- sequencer ----
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    p_d         = p_q;
    step_d      = step_q;
    axis_d      = axis_q;
    valid_d     = 1'b0;
    sat_d       = sat_q;
    t1_d        = '0;
    t2_d        = t1_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    force_x_d   = force_x_q;
    force_y_d   = force_y_q;
    force_z_d   = force_z_q;
    saturated_d = saturated_q;

    // accumulate stage behind the multiplier register
    if (t2_q.valid) begin
      case (t2_q.mode)
        MODE_MAC: acc_d  = acc_q + mul_q[AccW-1:0];
        MODE_LO:  prod_d = prod_q + ProdW'(mul_q[PartW-1:0]);
        MODE_HI:  prod_d = prod_q + ProdW'({mul_q[PartW-1:0], {HalfW{1'b0}}});
        default:  ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start && (action_i == ACT_QUERY)) begin
          x_d     = in_x[XW-1:0];
          y_d     = in_y[YW-1:0];
          z_d     = in_z[ZW-1:0];
          k_d     = '0;
          axis_d  = AXIS_X;
          acc_d   = '0;
          sat_d   = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        t1_d = '{valid: 1'b1, mode: MODE_MAC, weight: stencil_weight(order_q, k_q)};
        k_d  = k_q + 3'd1;
        if (k_q == last_k) state_d = ST_MDRAIN;
      end
      ST_MDRAIN: begin
        if (pipe_empty) begin
          neg_d   = acc_q[AccW-1];
          mag_d   = acc_q[AccW-1] ? acc_neg[MagW-1:0] : acc_q[MagW-1:0];
          prod_d  = round_bias(order_q);
          p_d     = 1'b0;
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        t1_d = '{valid: 1'b1, mode: (p_q ? MODE_HI : MODE_LO), weight: '0};
        p_d  = ~p_q;
        if (p_q) state_d = ST_PDRAIN;
      end
      ST_PDRAIN: begin
        if (pipe_empty) begin
          // power-of-two part of the denominator goes out as a shift
          div_d   = (order_q == ORDER_2ND) ? DivW'(prod_q[ProdW-1:ShiftOrd2])
                                           : DivW'(prod_q[ProdW-1:ShiftOrdN]);
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_d = {quot_q[DivW-DigitW-1:0], digit_res[DigitW+RemW-1:RemW]};
        rem_d  = digit_res[RemW-1:0];
        div_d  = div_q << DigitW;
        step_d = step_q + 3'd1;
        if (step_q == 3'(DivSteps - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        unique case (axis_q)
          AXIS_X:  force_x_d = force_val;
          AXIS_Y:  force_y_d = force_val;
          default: force_z_d = force_val;
        endcase
        sat_d = sat_q | over;
        if (axis_q == AXIS_Z) begin
          saturated_d = sat_q | over;
          valid_d     = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          k_d     = '0;
          acc_d   = '0;
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      p_q     <= 1'b0;
      step_q  <= '0;
      axis_q  <= AXIS_X;
      t1_q    <= '0;
      t2_q    <= '0;
      valid_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      p_q     <= p_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      valid_q <= valid_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    z_q         <= z_d;
    mul_q       <= mul_d;
    acc_q       <= acc_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    prod_q      <= prod_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    force_x_q   <= force_x_d;
    force_y_q   <= force_y_d;
    force_z_q   <= force_z_d;
    saturated_q <= saturated_d;
  end

  assign valid_o     = valid_q;
  assign force_x_o   = force_x_q;
  assign force_y_o   = force_y_q;
  assign force_z_o   = force_z_q;
  assign saturated_o = saturated_q;

  // ---- assertions ----
  `ASSERT_NEXT(a_result_after_last_axis, clk_i, rst_ni, state_q == ST_FIN && axis_q == AXIS_Z, valid_q && !busy)
  `ASSERT_IMPLY(a_pipe_empty_when_idle, clk_i, rst_ni, state_q == ST_IDLE, !t1_q.valid && !t2_q.valid)
  `ASSERT_NEXT(a_result_single_cycle, clk_i, rst_ni, valid_q, !valid_q)
  `ASSERT_IMPLY(a_read_in_range, clk_i, rst_ni, state_q == ST_READ, k_q <= last_k)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pgs3d_pkg::*;

  localparam int GridCells = GridXDefault * GridYDefault * GridZDefault;
  localparam int StallLimit = 2000;

  localparam logic [1:0] ORDER_6TH  = 2'd2;
  localparam logic [1:0] ORDER_SEL3 = 2'd3;  // unused selector code, acts as sixth order

  localparam int SampleMax = 32'sh7FFF_FFFF;
  localparam int SampleMin = 32'sh8000_0000;

  typedef struct packed {
    logic [IndexW-1:0] x;
    logic [IndexW-1:0] y;
    logic [IndexW-1:0] z;
  } grid_point_t;

  typedef struct packed {
    logic [DataW-1:0] fx;
    logic [DataW-1:0] fy;
    logic [DataW-1:0] fz;
    logic             sat;
  } force_word_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic                    action_i    = ACT_WRITE;
  logic [IndexW-1:0]       index_x_i   = '0;
  logic [IndexW-1:0]       index_y_i   = '0;
  logic [IndexW-1:0]       index_z_i   = '0;
  logic signed [DataW-1:0] potential_i = '0;
  logic                    valid_o;
  logic signed [DataW-1:0] force_x_o;
  logic signed [DataW-1:0] force_y_o;
  logic signed [DataW-1:0] force_z_o;
  logic                    saturated_o;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [RegAddrW-1:0]     paddr       = '0;
  logic [DataW-1:0]        pwdata      = '0;
  logic [DataW-1:0]        prdata;
  logic                    pready;

  // shadow of the grid and of the register file
  int               grid_mirror  [0:GridCells-1];
  bit               grid_written [0:GridCells-1];
  logic [1:0]       cfg_order = ORDER_2ND;
  logic [DataW-1:0] cfg_inv [0:2] = '{InvReset, InvReset, InvReset};

  force_word_t pending_forces[$];
  int          errors       = 0;
  int          items_sent   = 0;
  int          stall_cycles = 0;
  bit          idle_enable  = 1'b1;

  periodic_gradient_stencil_3d_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .index_x_i   (index_x_i),
    .index_y_i   (index_y_i),
    .index_z_i   (index_z_i),
    .potential_i (potential_i),
    .valid_o     (valid_o),
    .force_x_o   (force_x_o),
    .force_y_o   (force_y_o),
    .force_z_o   (force_z_o),
    .saturated_o (saturated_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int cell_addr(input grid_point_t p);
    return (int'(p.x) * GridYDefault + int'(p.y)) * GridZDefault + int'(p.z);
  endfunction

  // periodic neighbour, off steps along one axis
  function automatic grid_point_t step_point(input grid_point_t p, input int axis,
                                             input int off);
    grid_point_t q;
    q = p;
    if (axis == AXIS_X)      q.x = IndexW'((int'(p.x) + GridXDefault + off) % GridXDefault);
    else if (axis == AXIS_Y) q.y = IndexW'((int'(p.y) + GridYDefault + off) % GridYDefault);
    else                     q.z = IndexW'((int'(p.z) + GridZDefault + off) % GridZDefault);
    return q;
  endfunction

  // returns {clipped, force}
  function automatic logic [DataW:0] axis_force(input grid_point_t p, input int axis,
                                                input logic [DataW-1:0] inv);
    longint           diff [1:3];
    longint           wsum;
    longint unsigned  den, mag, hi, lo, quo, rem, tail, lim;
    logic             neg, clip;
    for (int k = 1; k <= 3; k++)
      diff[k] = longint'(grid_mirror[cell_addr(step_point(p, axis, k))]) -
                longint'(grid_mirror[cell_addr(step_point(p, axis, -k))]);
    case (cfg_order)
      ORDER_2ND: begin
        wsum = diff[1];
        den  = 2;
      end
      ORDER_4TH: begin
        wsum = 8 * diff[1] - diff[2];
        den  = 12;
      end
      default: begin
        wsum = 45 * diff[1] - 9 * diff[2] + diff[3];
        den  = 60;
      end
    endcase
    neg = wsum < 0;
    mag = neg ? -wsum : wsum;
    // |S| * inv / (D * 2^16), nearest, ties away from zero, split to stay in 64 bits
    hi   = mag * inv[31:16];
    lo   = mag * inv[15:0];
    quo  = hi / den;
    rem  = hi % den;
    tail = (rem << 16) + lo + den * 32768;
    mag  = quo + tail / (den * 65536);
    lim  = neg ? 64'h7FFF_FFFF : 64'h8000_0000;
    clip = mag > lim;
    if (clip) mag = lim;
    if (!neg) mag = -mag;
    return {clip, mag[31:0]};
  endfunction

  function automatic force_word_t predict_force(input grid_point_t p);
    logic [DataW:0] fx, fy, fz;
    force_word_t    w;
    fx = axis_force(p, AXIS_X, cfg_inv[AXIS_X]);
    fy = axis_force(p, AXIS_Y, cfg_inv[AXIS_Y]);
    fz = axis_force(p, AXIS_Z, cfg_inv[AXIS_Z]);
    w.fx  = fx[DataW-1:0];
    w.fy  = fy[DataW-1:0];
    w.fz  = fz[DataW-1:0];
    w.sat = fx[DataW] | fy[DataW] | fz[DataW];
    return w;
  endfunction

  function automatic logic [DataW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SampleMax;
      1:       return SampleMin;
      2, 3:    return DataW'(int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_spacing();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return InvReset;
      3:       return $urandom_range(0, 32'h3_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // mostly near the wrap seam so that neighbourhoods get reused
  function automatic logic [IndexW-1:0] pick_axis_coord();
    if ($urandom_range(0, 7) < 6) return IndexW'((30 + $urandom_range(0, 4)) % 32);
    return IndexW'($urandom_range(0, 31));
  endfunction

  task automatic send_word(input logic act, input grid_point_t p,
                           input logic [DataW-1:0] pot);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    action_i    <= act;
    index_x_i   <= p.x;
    index_y_i   <= p.y;
    index_z_i   <= p.z;
    potential_i <= pot;
    do @(posedge clk_i); while (busy);
    if (act == ACT_WRITE) begin
      grid_mirror[cell_addr(p)]  = pot;
      grid_written[cell_addr(p)] = 1'b1;
    end else begin
      pending_forces.push_back(predict_force(p));
    end
    items_sent++;
  endtask

  // writes every neighbour the current order reads that is still blank, plus a few rewrites
  task automatic prepare_stencil(input grid_point_t p);
    int          reach;
    grid_point_t n;
    reach = (cfg_order == ORDER_2ND) ? 1 : (cfg_order == ORDER_4TH) ? 2 : 3;
    for (int ax = 0; ax < 3; ax++) begin
      for (int k = -reach; k <= reach; k++) begin
        n = step_point(p, ax, k);
        if (k != 0 && (!grid_written[cell_addr(n)] || $urandom_range(0, 7) == 0))
          send_word(ACT_WRITE, n, pick_sample());
      end
    end
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_forces.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic [1:0] idx,
                           input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [DataW-1:0] got, want;
    apb_cycle(1'b0, idx, '0, got);
    case (idx)
      REG_ORDER: want = DataW'(cfg_order);
      REG_INV_X: want = cfg_inv[AXIS_X];
      REG_INV_Y: want = cfg_inv[AXIS_Y];
      REG_INV_Z: want = cfg_inv[AXIS_Z];
    endcase
    if (got !== want) begin
      $error("register %0d mismatch: expected %h, got %h", idx, want, got);
      errors++;
    end
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] ignored;
    settle_block();
    apb_cycle(1'b1, idx, value, ignored);
    case (idx)
      REG_ORDER: cfg_order = value[1:0];
      REG_INV_X: cfg_inv[AXIS_X] = value;
      REG_INV_Y: cfg_inv[AXIS_Y] = value;
      REG_INV_Z: cfg_inv[AXIS_Z] = value;
    endcase
    check_register(idx);
  endtask

  task automatic test_register_access();
    for (int i = 0; i < 4; i++) check_register(2'(i));
    program_register(REG_ORDER, ORDER_SEL3);
    program_register(REG_INV_X, 32'hFFFF_FFFF);
    program_register(REG_INV_Y, '0);
    program_register(REG_INV_Z, $urandom());
  endtask

  // full-scale opposing samples on x and y, small ones on z, around the origin, so every neighbour wraps on one side
  task automatic test_directed_stencils();
    int          table_x [0:5] = '{SampleMax, SampleMin, SampleMin, SampleMax, SampleMax, SampleMin};
    int          table_y [0:5] = '{SampleMin, SampleMax, SampleMax, SampleMin, SampleMin, SampleMax};
    int          table_z [0:5] = '{1, 0, -5, 7, 2, -11};
    grid_point_t origin;
    int          off;
    origin = '0;
    program_register(REG_ORDER, ORDER_2ND);
    program_register(REG_INV_X, InvReset);
    program_register(REG_INV_Y, InvReset);
    program_register(REG_INV_Z, InvReset);
    // k = 0..5 is p1, m1, p2, m2, p3, m3
    for (int k = 0; k < 6; k++) begin
      off = (k / 2 + 1) * ((k % 2) ? -1 : 1);
      send_word(ACT_WRITE, step_point(origin, AXIS_X, off), table_x[k]);
      send_word(ACT_WRITE, step_point(origin, AXIS_Y, off), table_y[k]);
      send_word(ACT_WRITE, step_point(origin, AXIS_Z, off), table_z[k]);
    end
    // z gives a half-way tie at second order
    send_word(ACT_QUERY, origin, SampleMax);
    program_register(REG_ORDER, ORDER_4TH);
    send_word(ACT_QUERY, origin, SampleMin);
    program_register(REG_ORDER, ORDER_6TH);
    program_register(REG_INV_X, 32'hFFFF_FFFF);
    program_register(REG_INV_Y, 32'hFFFF_FFFF);
    program_register(REG_INV_Z, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, origin, '0);
    program_register(REG_ORDER, ORDER_SEL3);
    program_register(REG_INV_X, '0);
    send_word(ACT_QUERY, origin, $urandom());
  endtask

  task automatic test_random_stencils();
    int          quota;
    grid_point_t p;
    for (int phase = 0; phase < 6; phase++) begin
      program_register(REG_ORDER, (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3)));
      program_register(REG_INV_X, pick_spacing());
      program_register(REG_INV_Y, pick_spacing());
      program_register(REG_INV_Z, pick_spacing());
      idle_enable = (phase != 5);
      quota = items_sent + 92;
      while (items_sent < quota) begin
        if ($urandom_range(0, 9) < 2) begin
          p.x = IndexW'($urandom());
          p.y = IndexW'($urandom());
          p.z = IndexW'($urandom());
          send_word(ACT_WRITE, p, pick_sample());
        end else begin
          p.x = pick_axis_coord();
          p.y = pick_axis_coord();
          p.z = pick_axis_coord();
          prepare_stencil(p);
          send_word(ACT_QUERY, p, $urandom());
        end
      end
    end
  endtask

  // result words cannot be held off, so each is checked in its one valid cycle
  always @(posedge clk_i) begin
    force_word_t want;
    if (rst_ni && valid_o) begin
      if (pending_forces.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_forces.pop_front();
        if (force_x_o !== want.fx) begin
          $error("force_x mismatch: expected %h, got %h", want.fx, force_x_o);
          errors++;
        end
        if (force_y_o !== want.fy) begin
          $error("force_y mismatch: expected %h, got %h", want.fy, force_y_o);
          errors++;
        end
        if (force_z_o !== want.fz) begin
          $error("force_z mismatch: expected %h, got %h", want.fz, force_z_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated mismatch: expected %b, got %b", want.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_directed_stencils();
    test_random_stencils();
    settle_block();
    repeat (70) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== periodic_gradient_stencil_3d_unit.f =====
+incdir+src
src/pgs3d_pkg.sv
src/periodic_gradient_stencil_3d_unit.sv
sim/tb_top.sv
